### rtl/osar_pkg.sv
// Shared types and action codes for the ordered key set.
package osar_pkg;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam int KEY_IN_W = 32;
    localparam int POS_OUT_W = 4;
    localparam int CNT_OUT_W = 5;

    typedef struct packed {
        logic [1:0]          action;
        logic [KEY_IN_W-1:0] key;
    } cmd_word_t;

    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] position;
        logic [CNT_OUT_W-1:0] count;
        logic                 full_drop;
    } res_word_t;

    // Broadcast to every cell in the row for the word being executed.
    typedef struct packed {
        logic add_ok;   // append the key at the tail
        logic rem_ok;   // close the gap at the matching entry
    } cell_cmd_t;

endpackage

### rtl/ordered_set_add_remove_lookup.sv
// Ordered key set: top level with the cell row, count and result register.
//
// Command channel (cmd_valid / cmd_stall / cmd): one word carries an action
// (add, remove, query; code 3 acts as query) and a key. Result channel
// (res_valid / res_stall / res): exactly one word per command with found,
// position, count after the action and full_drop.
// Keys sit in a row of CAPACITY cells in insertion order. Every cell compares
// its entry against the key in parallel; a remove shifts each cell at or past
// the hit one place toward the head, an add loads the cell at the tail.
// The result is registered and is valid the cycle after the command is taken.
// Throughput: one command per cycle while cmd_stall is low; the whole compare
// and shift across the cell row is combinational, so the row is the limit.
// The result register lets a new command enter in the same cycle the previous
// result is taken. While res_valid is high and res_stall is high, cmd_stall
// is raised and the result word is held unchanged.
// Reset (rst_n low, asynchronous) empties the set and clears res_valid;
// stored keys are left as they are and are never compared until rewritten.
module ordered_set_add_remove_lookup #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  osar_pkg::cmd_word_t  cmd,
    output logic                 res_valid,
    input  logic                 res_stall,
    output osar_pkg::res_word_t  res
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                    accept;
    logic [KEY_WIDTH-1:0]    lookup_key;
    logic [KEY_WIDTH-1:0]    row_key [CAPACITY];
    logic [CAPACITY-1:0]     match_vec;
    logic                    hit;
    logic [IDX_W-1:0]        hit_pos;
    logic                    is_add;
    logic                    is_remove;
    logic                    full;
    osar_pkg::cell_cmd_t     cell_cmd;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    res_valid_reg;
    logic                    res_valid_next;
    osar_pkg::res_word_t     res_reg;
    osar_pkg::res_word_t     res_next;

    assign cmd_stall  = res_valid_reg && res_stall;
    assign accept     = cmd_valid && !cmd_stall;
    assign lookup_key = KEY_WIDTH'(cmd.key);

    assign is_add    = cmd.action == osar_pkg::ACT_ADD;
    assign is_remove = cmd.action == osar_pkg::ACT_REMOVE;
    assign full      = count_reg >= CNT_W'(CAPACITY);

    assign cell_cmd.add_ok = accept && is_add && !hit && !full;
    assign cell_cmd.rem_ok = accept && is_remove && hit;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [KEY_WIDTH-1:0] neighbor_key;

            if (g == CAPACITY - 1)
            begin : g_last
                assign neighbor_key = '0;
            end
            else
            begin : g_mid
                assign neighbor_key = row_key[g + 1];
            end

            osar_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .IDX_W     (IDX_W),
                .CNT_W     (CNT_W),
                .INDEX     (g)
            ) u_cell (
                .clk        (clk),
                .cmd        (cell_cmd),
                .key        (lookup_key),
                .count      (count_reg),
                .pos        (hit_pos),
                .next_key   (neighbor_key),
                .stored_key (row_key[g]),
                .match      (match_vec[g])
            );
        end
    endgenerate

    // Keys are unique, so at most one cell matches; an OR tree gives its index.
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i])
            begin
                hit     = 1'b1;
                hit_pos = hit_pos | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        priority if (cell_cmd.add_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cell_cmd.rem_ok)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        res_next           = res_reg;
        res_valid_next     = res_valid_reg && res_stall;
        if (accept)
        begin
            res_valid_next     = 1'b1;
            res_next.found     = hit;
            res_next.position  = osar_pkg::POS_OUT_W'(hit_pos);
            res_next.count     = osar_pkg::CNT_OUT_W'(count_next);
            res_next.full_drop = is_add && !hit && full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("set count above capacity");

    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("key stored in more than one cell");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cell_cmd.add_ok |=> count_reg == $past(count_reg) + 1'b1)
        else $error("add did not grow the set");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cell_cmd.rem_ok |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not shrink the set");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("accepted word produced no result");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_add && !hit && full |=> res_reg.full_drop)
        else $error("add into full set not flagged");

endmodule

### rtl/osar_cell.sv
// One storage cell of the key row: holds one entry, compares, appends, shifts.
module osar_cell #(
    parameter int KEY_WIDTH = 32,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5,
    parameter int INDEX     = 0
) (
    input  logic                   clk,
    input  osar_pkg::cell_cmd_t    cmd,
    input  logic [KEY_WIDTH-1:0]   key,
    input  logic [CNT_W-1:0]       count,
    input  logic [IDX_W-1:0]       pos,
    input  logic [KEY_WIDTH-1:0]   next_key,
    output logic [KEY_WIDTH-1:0]   stored_key,
    output logic                   match
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 occupied;
    logic                 is_tail;
    logic                 at_or_after;

    assign occupied    = CNT_W'(INDEX) < count;
    assign is_tail     = CNT_W'(INDEX) == count;
    assign at_or_after = IDX_W'(INDEX) >= pos;
    assign match       = occupied && (key_reg == key);
    assign stored_key  = key_reg;

    always_comb
    begin
        priority if (cmd.add_ok && is_tail)
        begin
            key_next = key;
        end
        else if (cmd.rem_ok && at_or_after)
        begin
            key_next = next_key;
        end
        else
        begin
            key_next = key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

### tb/sv/tb_top.sv
// Testbench for the ordered key set: command driver, result checker and key-set predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int CAP            = 16;
    localparam int POOL_SIZE      = 24;
    localparam int RANDOM_WORDS   = 925;
    localparam int HOLD_CYCLES    = 50;
    localparam int WATCHDOG_LIMIT = 1000;
    // action code 3 is unused by the block and behaves as a query
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    // Mirrors the stored keys and queues the expected result word per command.
    class key_set_scoreboard;
        logic [osar_pkg::KEY_IN_W-1:0] stored_keys[CAP];
        int unsigned stored_n;
        osar_pkg::res_word_t expected_res[$];
        int unsigned errors;
        int unsigned n_cmds;
        int unsigned n_checked;
        int unsigned n_hits;
        int unsigned n_drops;

        function new();
            stored_n  = 0;
            errors    = 0;
            n_cmds    = 0;
            n_checked = 0;
            n_hits    = 0;
            n_drops   = 0;
        endfunction

        function void apply_cmd(osar_pkg::cmd_word_t w);
            osar_pkg::res_word_t exp_w;
            bit hit;
            int unsigned hit_at;
            hit    = 1'b0;
            hit_at = 0;
            for (int i = 0; i < stored_n; i++) begin
                if (!hit && stored_keys[i] == w.key) begin
                    hit    = 1'b1;
                    hit_at = i;
                end
            end
            exp_w          = '0;
            exp_w.found    = hit;
            exp_w.position = hit_at[osar_pkg::POS_OUT_W-1:0];
            case (w.action)
                osar_pkg::ACT_ADD:
                begin
                    if (!hit) begin
                        if (stored_n < CAP) begin
                            stored_keys[stored_n] = w.key;
                            stored_n++;
                        end else begin
                            exp_w.full_drop = 1'b1;
                            n_drops++;
                        end
                    end
                end
                osar_pkg::ACT_REMOVE:
                begin
                    if (hit) begin
                        for (int i = hit_at; i + 1 < stored_n; i++)
                            stored_keys[i] = stored_keys[i + 1];
                        stored_n--;
                    end
                end
                default: ;
            endcase
            exp_w.count = stored_n[osar_pkg::CNT_OUT_W-1:0];
            if (hit)
                n_hits++;
            n_cmds++;
            expected_res.insert(expected_res.size(), exp_w);
        endfunction

        function void report(string what, logic [31:0] exp_v, logic [31:0] got_v);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v,
                     got_v);
        endfunction

        function void check_res(osar_pkg::res_word_t got);
            osar_pkg::res_word_t exp_w;
            n_checked++;
            if (expected_res.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing expected, actual %p", $time, got);
                return;
            end
            exp_w = expected_res.pop_front();
            if (got.found !== exp_w.found)
                report("found", exp_w.found, got.found);
            if (got.position !== exp_w.position)
                report("position", exp_w.position, got.position);
            if (got.count !== exp_w.count)
                report("count", exp_w.count, got.count);
            if (got.full_drop !== exp_w.full_drop)
                report("full_drop", exp_w.full_drop, got.full_drop);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    osar_pkg::cmd_word_t cmd;
    logic                res_valid;
    logic                res_stall;
    osar_pkg::res_word_t res;

    bit calm;
    bit hold_req;
    int unsigned quiet;
    logic [osar_pkg::KEY_IN_W-1:0] key_pool[POOL_SIZE];

    key_set_scoreboard sb = new();

    ordered_set_add_remove_lookup u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic osar_pkg::cmd_word_t mk_cmd(logic [1:0] act,
                                                   logic [osar_pkg::KEY_IN_W-1:0] k);
        osar_pkg::cmd_word_t w;
        w.action = act;
        w.key    = k;
        return w;
    endfunction

    // Offer one word; hold it steady until the block takes it.
    task automatic send_word(input osar_pkg::cmd_word_t w);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 22) begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd       = w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.apply_cmd(w);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        bit held;
        held      = 1'b0;
        res_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !held) begin
                res_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            res_stall = !calm && ($urandom_range(99) < 22);
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall)
            sb.check_res(res);
    end

    // Ends the run if nothing moves on either channel for too long.
    initial begin
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("ordered_set_add_remove_lookup verification failed");
        $finish;
    end

    initial begin
        mix_t        mix;
        int unsigned roll;
        logic [1:0]  act;
        logic [osar_pkg::KEY_IN_W-1:0] k;

        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        mix       = MIX_FILL;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty set, key extremes, duplicate, spare code, fill, overflow, removes
        send_word(mk_cmd(osar_pkg::ACT_QUERY, 32'h0000_0000));
        send_word(mk_cmd(osar_pkg::ACT_REMOVE, 32'hFFFF_FFFF));
        send_word(mk_cmd(osar_pkg::ACT_ADD, 32'h0000_0000));
        send_word(mk_cmd(osar_pkg::ACT_ADD, 32'hFFFF_FFFF));
        send_word(mk_cmd(osar_pkg::ACT_ADD, 32'h0000_0000));
        send_word(mk_cmd(ACT_SPARE, 32'hFFFF_FFFF));
        for (int i = 0; i < CAP - 2; i++)
            send_word(mk_cmd(osar_pkg::ACT_ADD, 32'hA5A5_0000 | (i * 32'h1111)));
        send_word(mk_cmd(osar_pkg::ACT_ADD, 32'h1234_5678));
        send_word(mk_cmd(osar_pkg::ACT_ADD, 32'hFFFF_FFFF));
        send_word(mk_cmd(osar_pkg::ACT_REMOVE, 32'hA5A5_0000 | (7 * 32'h1111)));
        send_word(mk_cmd(osar_pkg::ACT_REMOVE, 32'h0000_0000));
        send_word(mk_cmd(osar_pkg::ACT_REMOVE, 32'hA5A5_0000 | (13 * 32'h1111)));

        // small key pool so adds, hits, removes and overflow keep recurring
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 60 == 0)
                mix = mix_t'($urandom_range(2));
            if (n == RANDOM_WORDS / 4)
                hold_req = 1'b1;
            calm = (n >= 500 && n < 650);
            roll = $urandom_range(99);
            case (mix)
                MIX_FILL:  act = (roll < 60) ? osar_pkg::ACT_ADD :
                                 (roll < 75) ? osar_pkg::ACT_REMOVE :
                                 (roll < 95) ? osar_pkg::ACT_QUERY : ACT_SPARE;
                MIX_DRAIN: act = (roll < 20) ? osar_pkg::ACT_ADD :
                                 (roll < 75) ? osar_pkg::ACT_REMOVE :
                                 (roll < 95) ? osar_pkg::ACT_QUERY : ACT_SPARE;
                default:   act = (roll < 40) ? osar_pkg::ACT_ADD :
                                 (roll < 70) ? osar_pkg::ACT_REMOVE :
                                 (roll < 95) ? osar_pkg::ACT_QUERY : ACT_SPARE;
            endcase
            if ($urandom_range(99) < 85)
                k = key_pool[$urandom_range(POOL_SIZE - 1)];
            else
                k = $urandom;
            send_word(mk_cmd(act, k));
        end
        @(negedge clk);
        cmd_valid = 1'b0;
        calm      = 1'b0;

        while (sb.expected_res.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (sb.expected_res.size() != 0) begin
            sb.errors++;
            $display("%0t: result words outstanding, expected 0, actual %0d", $time,
                     sb.expected_res.size());
        end

        $display("Run covered %0d commands and %0d result words: %0d hits on stored keys,",
                 sb.n_cmds, sb.n_checked, sb.n_hits);
        $display("%0d adds refused on a full set, and a %0d-cycle result hold-off.",
                 sb.n_drops, HOLD_CYCLES);
        if (sb.errors == 0)
            $display("ordered_set_add_remove_lookup verification clean");
        else
            $display("ordered_set_add_remove_lookup verification failed");
        $finish;
    end

endmodule
